### hw/rtl/ddrt_pkg.sv
// shared types and constants for the dedupe digest refcount table
// no dependencies
`default_nettype none

package ddrt_pkg;

   localparam int SLOTS_PER_BLOCK = 8;
   localparam int META_BLOCKS     = 128;
   localparam int DIGEST_BYTES    = 16;
   localparam int SPREAD_GROUP    = 64;
   localparam int SLOT_COUNT      = META_BLOCKS * SLOTS_PER_BLOCK;
   localparam int SLOT_BITS       = 10;
   localparam int BLOCK_SHIFT     = $clog2(SLOTS_PER_BLOCK);
   localparam int GROUP_COUNT     = META_BLOCKS / SPREAD_GROUP;
   localparam int GROUP_BITS      = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
   localparam int START_SHIFT     = $clog2(SLOTS_PER_BLOCK * SPREAD_GROUP);
   localparam int DIGEST_HALF     = DIGEST_BYTES * 4;

   localparam logic [1:0] ACT_SEARCH = 2'd0;
   localparam logic [1:0] ACT_ADD    = 2'd1;
   localparam logic [1:0] ACT_DELETE = 2'd2;

   typedef enum logic [1:0] {
      STATUS_DONE   = 2'd0,
      STATUS_MISS   = 2'd1,
      STATUS_REJECT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CMD_SEARCH,
      CMD_ADD,
      CMD_DELETE,
      CMD_REJECT,
      CMD_NOP
   } cmd_kind_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN
   } engine_state_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic [DIGEST_HALF-1:0] digest_lo;
      logic [DIGEST_HALF-1:0] digest_hi;
      logic [31:0]            address;
      logic [SLOT_BITS-1:0]   start;
   } cmd_type;

   typedef struct packed {
      logic [DIGEST_HALF-1:0] digest_lo;
      logic [DIGEST_HALF-1:0] digest_hi;
      logic [31:0]            address;
      logic [15:0]            refs;
   } slot_entry_type;

   typedef struct packed {
      status_type           status;
      logic [SLOT_BITS-1:0] slot;
      logic [31:0]          address;
      logic [15:0]          refs;
      logic [6:0]           dirty;
   } result_type;

endpackage

`default_nettype wire

### hw/rtl/ddrt_ram.sv
// generic simple dual port ram with registered read
// no dependencies
`default_nettype none

module ddrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### hw/rtl/ddrt_front.sv
// request intake: marker register, action decode and a two-entry command queue
// depends on ddrt_pkg
`default_nettype none

module ddrt_front import ddrt_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_wr_en,
   input  wire logic [31:0]   csr_wr_data,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [159:0]  req_tdata,
   input  wire logic [1:0]    req_tuser,
   output logic               cmd_valid,
   output cmd_type            cmd,
   input  wire logic          cmd_pop
);

   logic [31:0] marker_ff;
   cmd_type     queue_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;
   cmd_type     decoded;
   logic        push;

   always_comb begin
      decoded.digest_lo = req_tdata[63:0];
      decoded.digest_hi = req_tdata[127:64];
      decoded.address   = req_tdata[159:128];
      decoded.start     = SLOT_BITS'({{(SLOT_BITS-GROUP_BITS){1'b0}},
                          req_tdata[GROUP_BITS-1:0]} << START_SHIFT);
      unique case (req_tuser)
         ACT_SEARCH: decoded.kind = CMD_SEARCH;
         ACT_ADD:    decoded.kind = CMD_ADD;
         ACT_DELETE: decoded.kind = (req_tdata[159:128] == marker_ff) ? CMD_REJECT
                                                                       : CMD_DELETE;
         default:    decoded.kind = CMD_NOP;
      endcase
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (count_ff != 2'd0);
   assign cmd        = queue_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= 32'hFFFF_FFFF;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (csr_wr_en) begin
            marker_ff <= csr_wr_data;
         end
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (cmd_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(cmd_pop);
      end
   end

endmodule

`default_nettype wire

### hw/rtl/ddrt_engine.sv
// slot table sequencer: clearing pass, wrapping scans, refcount updates, result register
// depends on ddrt_pkg and ddrt_ram
`default_nettype none

module ddrt_engine import ddrt_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         cmd_valid,
   input  cmd_type           cmd,
   output logic              cmd_pop,
   output logic              out_valid,
   input  wire logic         out_ready,
   output result_type        out_result
);

   localparam int ENTRY_BITS = $bits(slot_entry_type);

   engine_state_type     state_ff, state_in;
   cmd_type              cur_ff, cur_in;
   logic [SLOT_BITS:0]   cnt_ff, cnt_in;
   logic [SLOT_BITS-1:0] ptr_ff, ptr_in;
   logic [SLOT_BITS-1:0] resume_ff, resume_in;
   logic                 pend_ff, pend_in;
   logic                 last_ff, last_in;
   logic [SLOT_BITS-1:0] rslot_ff, rslot_in;
   logic                 valid_ff, valid_in;
   result_type           res_ff, res_in;

   logic                 we, re;
   logic [SLOT_BITS-1:0] waddr, raddr;
   slot_entry_type       wentry, rentry;
   logic [ENTRY_BITS-1:0] rd_data;
   logic                 hit;
   logic [15:0]          dec_refs;

   ddrt_ram #(.WIDTH(ENTRY_BITS), .DEPTH(SLOT_COUNT)) u_table (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (ENTRY_BITS'(wentry)),
      .rd_en   (re),
      .rd_addr (raddr),
      .rd_data (rd_data)
   );

   assign rentry   = slot_entry_type'(rd_data);
   assign dec_refs = rentry.refs - 16'd1;

   always_comb begin
      unique case (cur_ff.kind)
         CMD_SEARCH: hit = (rentry.refs != 16'd0) && (rentry.digest_lo == cur_ff.digest_lo)
                           && (rentry.digest_hi == cur_ff.digest_hi);
         CMD_ADD:    hit = (rentry.refs == 16'd0);
         CMD_DELETE: hit = (rentry.refs != 16'd0) && (rentry.address == cur_ff.address);
         default:    hit = 1'b0;
      endcase
      hit = hit && pend_ff;
   end

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      cnt_in    = cnt_ff;
      ptr_in    = ptr_ff;
      resume_in = resume_ff;
      pend_in   = 1'b0;
      last_in   = 1'b0;
      rslot_in  = rslot_ff;
      valid_in  = valid_ff && !out_ready;
      res_in    = res_ff;
      cmd_pop   = 1'b0;
      we        = 1'b0;
      waddr     = ptr_ff;
      wentry    = '0;
      re        = 1'b0;
      raddr     = ptr_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            we     = 1'b1;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == SLOT_BITS'(SLOT_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid && !valid_ff) begin
               cmd_pop = 1'b1;
               cur_in  = cmd;
               if (cmd.kind == CMD_REJECT || cmd.kind == CMD_NOP) begin
                  valid_in      = 1'b1;
                  res_in        = '0;
                  res_in.status = (cmd.kind == CMD_REJECT) ? STATUS_REJECT : STATUS_MISS;
               end else begin
                  state_in = ST_SCAN;
                  cnt_in   = '0;
                  ptr_in   = (cmd.kind == CMD_DELETE) ? resume_ff : cmd.start;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               state_in       = ST_IDLE;
               valid_in       = 1'b1;
               res_in.status  = STATUS_DONE;
               res_in.slot    = rslot_ff;
               res_in.address = rentry.address;
               res_in.refs    = rentry.refs;
               res_in.dirty   = 7'(rslot_ff >> BLOCK_SHIFT);
               waddr          = rslot_ff;
               wentry         = rentry;
               unique case (cur_ff.kind)
                  CMD_ADD: begin
                     we               = 1'b1;
                     wentry.digest_lo = cur_ff.digest_lo;
                     wentry.digest_hi = cur_ff.digest_hi;
                     wentry.address   = cur_ff.address;
                     wentry.refs      = 16'd1;
                  end
                  CMD_DELETE: begin
                     we             = 1'b1;
                     resume_in      = rslot_ff;
                     wentry.refs    = dec_refs;
                     if (dec_refs == 16'd0) begin
                        wentry.address = '0;
                     end
                  end
                  default: begin
                     res_in.dirty = '0;
                  end
               endcase
               res_in.address = wentry.address;
               res_in.refs    = wentry.refs;
            end else if (pend_ff && last_ff) begin
               state_in      = ST_IDLE;
               valid_in      = 1'b1;
               res_in        = '0;
               res_in.status = STATUS_MISS;
            end else if (cnt_ff != (SLOT_BITS+1)'(SLOT_COUNT)) begin
               re       = 1'b1;
               pend_in  = 1'b1;
               last_in  = (cnt_ff == (SLOT_BITS+1)'(SLOT_COUNT - 1));
               rslot_in = ptr_ff;
               ptr_in   = ptr_ff + 1'b1;
               cnt_in   = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         ptr_ff    <= '0;
         resume_ff <= '0;
         pend_ff   <= 1'b0;
         last_ff   <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ptr_ff    <= ptr_in;
         resume_ff <= resume_in;
         pend_ff   <= pend_in;
         last_ff   <= last_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      cnt_ff   <= cnt_in;
      rslot_ff <= rslot_in;
      res_ff   <= res_in;
   end

   assign out_valid  = valid_ff;
   assign out_result = res_ff;

endmodule

`default_nettype wire

### hw/rtl/dedupe_digest_refcount_table.sv
// top level of the dedupe digest refcount table
// depends on ddrt_pkg, ddrt_front and ddrt_engine
`default_nettype none

// After reset the block runs a clearing pass over all 1024 slots of the table
// and carries out no request in that time, though up to two requests are taken
// into the queue (marker writes are taken). A marker reject or an unused action
// is answered without a scan. Search, add and delete read one slot per cycle
// from the single table memory and stop at the first match, so the worst case
// is one full pass of 1024 slots. Up to two requests queue ahead of the scan,
// and a finished response waits in its own register while the next request is
// decoded; the scan of the next request starts only once that response has been
// taken.
module dedupe_digest_refcount_table import ddrt_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_wr_en,
   input  wire logic [31:0]   csr_wr_data,   // new_addr_marker
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [159:0]  req_tdata,     // digest_low, digest_high, block_address
   input  wire logic [1:0]    req_tuser,     // action
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [71:0]        rsp_tdata,     // entry_slot, entry_address, refs_left,
                                             // dirty_block, zero fill
   output logic [1:0]         rsp_tuser      // status
);

   logic       cmd_valid, cmd_pop;
   cmd_type    cmd;
   result_type result;

   ddrt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   ddrt_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tuser = result.status;
   assign rsp_tdata = {7'd0, result.dirty, result.refs, result.address, result.slot};

endmodule

`default_nettype wire

### hw/rtl/ddrt_checker.sv
// port-level checks for the dedupe digest refcount table, bound to the top level
// depends on dedupe_digest_refcount_table
`default_nettype none

module ddrt_checker (
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          rsp_tvalid,
   input wire logic          rsp_tready,
   input wire logic [71:0]   rsp_tdata,
   input wire logic [1:0]    rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("bad status code");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != 2'd0 |-> rsp_tdata == 72'd0)
      else $error("failed response carries data");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response after reset");

endmodule

bind dedupe_digest_refcount_table ddrt_checker u_ddrt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
